// ===== rtl/vot_pkg.sv =====
`default_nettype none

package vot_pkg;

  // Test selector codes carried on func
  typedef enum logic [2:0] {
    SPH_SPH  = 3'd0,
    SPH_AABB = 3'd1,
    SPH_OBB  = 3'd2,
    CAP_SPH  = 3'd3,
    CAP_AABB = 3'd4,
    CAP_OBB  = 3'd5
  } func_t;

  // Hits from the capsule/sphere lane
  typedef struct packed {
    logic sph_hit;
    logic cap_hit;
  } cap_flags_t;

  // Latency of every test lane, input ports to lane result register
  localparam int LANE_LAT = 8;

endpackage

`default_nettype wire

// ===== rtl/vot_wide_mul.sv =====
`default_nettype none

// Two-stage unsigned multiplier built from four half-width partial products
module vot_wide_mul #(
  parameter int HW = 17
) (
  input  wire logic            clk,
  input  wire logic [2*HW-1:0] a,
  input  wire logic [2*HW-1:0] b,
  output logic      [4*HW-1:0] prod
);

  localparam int PW = 4 * HW;

  logic [2*HW-1:0] ll, lh, hl, hh;

  // Stage 1: partial products
  always_ff @(posedge clk) begin
    ll <= (2*HW)'(a[HW-1:0])    * (2*HW)'(b[HW-1:0]);
    lh <= (2*HW)'(a[HW-1:0])    * (2*HW)'(b[2*HW-1:HW]);
    hl <= (2*HW)'(a[2*HW-1:HW]) * (2*HW)'(b[HW-1:0]);
    hh <= (2*HW)'(a[2*HW-1:HW]) * (2*HW)'(b[2*HW-1:HW]);
  end

  // Stage 2: shifted sum
  always_ff @(posedge clk) begin
    prod <= PW'(ll) + (PW'(lh) << HW) + (PW'(hl) << HW) + (PW'(hh) << (2*HW));
  end

endmodule

`default_nettype wire

// ===== rtl/vot_box_lane.sv =====
`default_nettype none

// Sphere against oriented box; an axis-aligned box runs with identity axes
module vot_box_lane #(
  parameter int CB = 16
) (
  input  wire logic            clk,
  input  wire logic [3*CB-1:0] pt,
  input  wire logic [3*CB-1:0] ctr,
  input  wire logic [3*CB-1:0] half,
  input  wire logic [3*CB-1:0] ax_one,
  input  wire logic [3*CB-1:0] ax_two,
  input  wire logic [3*CB-1:0] ax_three,
  input  wire logic [CB-1:0]   radius,
  input  wire logic            obb,
  output logic                 hit
);

  localparam int K  = CB - 2;
  localparam int DW = CB + 1;
  localparam int PW = 2 * CB + 1;
  localparam int SW = 2 * CB + 3;
  localparam int VW = SW - K;
  localparam int EW = CB + 6;
  localparam int QW = 2 * EW;
  localparam int TW = QW + 2;
  localparam int RW = 2 * CB;
  localparam logic [CB-1:0] IDENT = {1'b0, 1'b1, {K{1'b0}}};
  localparam logic [SW-1:0] RND   = SW'(1) << (K - 1);

  logic [3*CB-1:0] ax_in [3];

  logic signed [DW-1:0] d1 [3], d2 [3], d3 [3], d4 [3], d5 [3];
  logic signed [CB-1:0] ax1 [3][3], ax2 [3][3], ax3 [3][3];
  logic        [CB-1:0] h1 [3], h2 [3];
  logic        [CB-1:0] r1;
  logic        [RW-1:0] rr2, rr3, rr4, rr5, rr6, rr7;
  logic signed [PW-1:0] p2 [3][3], q4 [3][3];
  logic signed [CB:0]   cl3 [3];
  logic signed [CB:0]   cl_next [3];
  logic signed [VW-1:0] off5 [3];
  logic signed [VW-1:0] off_next [3];
  logic signed [EW-1:0] e6 [3];
  logic        [QW-1:0] sq7 [3];

  assign ax_in[0] = ax_one;
  assign ax_in[1] = ax_two;
  assign ax_in[2] = ax_three;

  // Stage 1: offset from box center, axis select
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      d1[j] <= DW'($signed(pt[j*CB +: CB])) - DW'($signed(ctr[j*CB +: CB]));
      h1[j] <= half[j*CB +: CB];
      for (int i = 0; i < 3; i++) begin
        if (obb) begin
          ax1[i][j] <= $signed(ax_in[i][j*CB +: CB]);
        end else begin
          ax1[i][j] <= (i == j) ? $signed(IDENT) : '0;
        end
      end
    end
    r1 <= radius;
  end

  // Stage 2: projection products
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p2[i][j] <= PW'(d1[j]) * PW'(ax1[i][j]);
      end
    end
    d2  <= d1;
    ax2 <= ax1;
    h2  <= h1;
    rr2 <= RW'(r1) * RW'(r1);
  end

  // Stage 3: local coordinate, rounded half up and clamped to the extent
  always_comb begin
    logic signed [SW-1:0] t;
    logic signed [VW-1:0] v;
    logic signed [VW-1:0] hs;
    for (int i = 0; i < 3; i++) begin
      t  = SW'(p2[i][0]) + SW'(p2[i][1]) + SW'(p2[i][2]) + $signed(RND);
      v  = $signed(t[SW-1:K]);
      hs = $signed(VW'(h2[i]));
      if (v > hs) begin
        v = hs;
      end else if (v < -hs) begin
        v = -hs;
      end
      cl_next[i] = v[CB:0];
    end
  end

  always_ff @(posedge clk) begin
    cl3 <= cl_next;
    d3  <= d2;
    ax3 <= ax2;
    rr3 <= rr2;
  end

  // Stage 4: back-projection products
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        q4[i][j] <= PW'(ax3[i][j]) * PW'(cl3[i]);
      end
    end
    d4  <= d3;
    rr4 <= rr3;
  end

  // Stage 5: world offset of the clamped point
  always_comb begin
    logic signed [SW-1:0] t;
    for (int j = 0; j < 3; j++) begin
      t = SW'(q4[0][j]) + SW'(q4[1][j]) + SW'(q4[2][j]) + $signed(RND);
      off_next[j] = $signed(t[SW-1:K]);
    end
  end

  always_ff @(posedge clk) begin
    off5 <= off_next;
    d5   <= d4;
    rr5  <= rr4;
  end

  // Stage 6: residual
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      e6[j] <= EW'(d5[j]) - EW'(off5[j]);
    end
    rr6 <= rr5;
  end

  // Stage 7: squares
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      sq7[j] <= QW'(QW'(e6[j]) * QW'(e6[j]));
    end
    rr7 <= rr6;
  end

  // Stage 8: distance against radius
  always_ff @(posedge clk) begin
    hit <= (TW'(sq7[0]) + TW'(sq7[1]) + TW'(sq7[2])) <= TW'(rr7);
  end

endmodule

`default_nettype wire

// ===== rtl/vot_cap_lane.sv =====
`default_nettype none

// Capsule against sphere, plus sphere against sphere on the same terms
module vot_cap_lane #(
  parameter int CB = 16
) (
  input  wire logic              clk,
  input  wire logic [3*CB-1:0]   pa,
  input  wire logic [3*CB-1:0]   pb,
  input  wire logic [3*CB-1:0]   ctr,
  input  wire logic [CB-1:0]     rad_a,
  input  wire logic [CB-1:0]     rad_b,
  output vot_pkg::cap_flags_t    flags
);

  localparam int DW = CB + 1;
  localparam int HW = CB + 1;
  localparam int SW = 2 * HW;
  localparam int PW = 4 * HW;

  logic signed [DW-1:0] ab1 [3], ap1 [3], bp1 [3];
  logic        [CB:0]   r1;
  logic signed [SW-1:0] abab2 [3], apap2 [3], apab2 [3], bpbp2 [3];
  logic        [SW-1:0] rr2, rr3;
  logic        [SW-1:0] len3, ap23, bp23;
  logic signed [SW:0]   dt3;
  logic                 sph4, near4, far4, farhit4;
  logic                 sph5, near5, far5, farhit5;
  logic                 sph6, sph7, sph8;
  logic                 cap6, cap7, cap8;
  logic        [PW-1:0] prod_ap, prod_dt, prod_rr;

  // Stage 1: segment and center offsets, radius sum
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      ab1[j] <= DW'($signed(pb[j*CB +: CB])) - DW'($signed(pa[j*CB +: CB]));
      ap1[j] <= DW'($signed(ctr[j*CB +: CB])) - DW'($signed(pa[j*CB +: CB]));
      bp1[j] <= DW'($signed(ctr[j*CB +: CB])) - DW'($signed(pb[j*CB +: CB]));
    end
    r1 <= (CB+1)'(rad_a) + (CB+1)'(rad_b);
  end

  // Stage 2: component products
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      abab2[j] <= SW'(ab1[j]) * SW'(ab1[j]);
      apap2[j] <= SW'(ap1[j]) * SW'(ap1[j]);
      apab2[j] <= SW'(ap1[j]) * SW'(ab1[j]);
      bpbp2[j] <= SW'(bp1[j]) * SW'(bp1[j]);
    end
    rr2 <= SW'(r1) * SW'(r1);
  end

  // Stage 3: dot products
  always_ff @(posedge clk) begin
    len3 <= $unsigned(abab2[0]) + $unsigned(abab2[1]) + $unsigned(abab2[2]);
    ap23 <= $unsigned(apap2[0]) + $unsigned(apap2[1]) + $unsigned(apap2[2]);
    bp23 <= $unsigned(bpbp2[0]) + $unsigned(bpbp2[1]) + $unsigned(bpbp2[2]);
    dt3  <= (SW+1)'(apab2[0]) + (SW+1)'(apab2[1]) + (SW+1)'(apab2[2]);
    rr3  <= rr2;
  end

  // Stage 4: end cases; wide products start here
  always_ff @(posedge clk) begin
    sph4    <= ap23 <= rr3;
    near4   <= (len3 == '0) || (dt3 <= (SW+1)'(0));
    far4    <= dt3 >= $signed({1'b0, len3});
    farhit4 <= bp23 <= rr3;
  end

  vot_wide_mul #(.HW(HW)) u_mul_ap (.clk(clk), .a(ap23), .b(len3), .prod(prod_ap));
  vot_wide_mul #(.HW(HW)) u_mul_dt (.clk(clk), .a(dt3[SW-1:0]), .b(dt3[SW-1:0]),
                                    .prod(prod_dt));
  vot_wide_mul #(.HW(HW)) u_mul_rr (.clk(clk), .a(rr3), .b(len3), .prod(prod_rr));

  // Stage 5: hold flags while products finish
  always_ff @(posedge clk) begin
    sph5    <= sph4;
    near5   <= near4;
    far5    <= far4;
    farhit5 <= farhit4;
  end

  // Stage 6: end cases, or interior case, |ap|^2 len2 - dt^2 <= r^2 len2
  always_ff @(posedge clk) begin
    sph6 <= sph5;
    if (near5) begin
      cap6 <= sph5;
    end else if (far5) begin
      cap6 <= farhit5;
    end else begin
      cap6 <= (PW+1)'(prod_ap) <= (PW+1)'(prod_dt) + (PW+1)'(prod_rr);
    end
  end

  // Stages 7 and 8: align with the box lanes
  always_ff @(posedge clk) begin
    sph7 <= sph6;
    cap7 <= cap6;
    sph8 <= sph7;
    cap8 <= cap7;
  end

  assign flags.sph_hit = sph8;
  assign flags.cap_hit = cap8;

endmodule

`default_nettype wire

// ===== rtl/volume_overlap_test_unit.sv =====
`default_nettype none

// Channel   Ports                                              Direction
// request   start, busy (out), func, first_start, first_end,   in
//           first_radius, second_center, second_radius,
//           half_size, axis_one, axis_two, axis_three
// result    done, overlaps                                     out
//
// One request per cycle; busy stays low. done and overlaps are registered
// in the result register, behind the lane result registers and the end of
// the valid chain that travels beside the lanes. rst (synchronous) clears
// only the valid chain and done; requests in flight are dropped. done is a
// one-cycle strobe and the pipeline never stalls.
module volume_overlap_test_unit #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [2:0]              func,
  input  wire logic [3*COORD_BITS-1:0] first_start,
  input  wire logic [3*COORD_BITS-1:0] first_end,
  input  wire logic [COORD_BITS-1:0]   first_radius,
  input  wire logic [3*COORD_BITS-1:0] second_center,
  input  wire logic [COORD_BITS-1:0]   second_radius,
  input  wire logic [3*COORD_BITS-1:0] half_size,
  input  wire logic [3*COORD_BITS-1:0] axis_one,
  input  wire logic [3*COORD_BITS-1:0] axis_two,
  input  wire logic [3*COORD_BITS-1:0] axis_three,
  output logic                         done,
  output logic                         overlaps
);

  localparam int CB  = COORD_BITS;
  localparam int LAT = vot_pkg::LANE_LAT;

  logic [3*CB-1:0]     mid;
  logic                obb;
  logic                hit_a, hit_b, hit_m;
  vot_pkg::cap_flags_t cflags;
  logic [LAT-1:0]      vld;
  logic [2:0]          fn [LAT];
  logic                hit_next;

  // Segment midpoint, rounded toward minus infinity
  always_comb begin
    logic signed [CB:0] s;
    for (int j = 0; j < 3; j++) begin
      s = (CB+1)'($signed(first_start[j*CB +: CB]))
        + (CB+1)'($signed(first_end[j*CB +: CB]));
      mid[j*CB +: CB] = s[CB:1];
    end
  end

  assign obb  = (func == vot_pkg::SPH_OBB) || (func == vot_pkg::CAP_OBB);
  assign busy = 1'b0;

  vot_box_lane #(.CB(CB)) u_box_a (
    .clk(clk), .pt(first_start), .ctr(second_center), .half(half_size),
    .ax_one(axis_one), .ax_two(axis_two), .ax_three(axis_three),
    .radius(first_radius), .obb(obb), .hit(hit_a)
  );

  vot_box_lane #(.CB(CB)) u_box_b (
    .clk(clk), .pt(first_end), .ctr(second_center), .half(half_size),
    .ax_one(axis_one), .ax_two(axis_two), .ax_three(axis_three),
    .radius(first_radius), .obb(obb), .hit(hit_b)
  );

  vot_box_lane #(.CB(CB)) u_box_m (
    .clk(clk), .pt(mid), .ctr(second_center), .half(half_size),
    .ax_one(axis_one), .ax_two(axis_two), .ax_three(axis_three),
    .radius(first_radius), .obb(obb), .hit(hit_m)
  );

  vot_cap_lane #(.CB(CB)) u_cap (
    .clk(clk), .pa(first_start), .pb(first_end), .ctr(second_center),
    .rad_a(first_radius), .rad_b(second_radius), .flags(cflags)
  );

  // Valid and selector travel beside the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start & ~busy};
    end
    fn[0] <= func;
    for (int k = 1; k < LAT; k++) begin
      fn[k] <= fn[k-1];
    end
  end

  // Pick the lane result for the requested test
  always_comb begin
    unique case (fn[LAT-1]) inside
      vot_pkg::SPH_SPH:                    hit_next = cflags.sph_hit;
      vot_pkg::SPH_AABB, vot_pkg::SPH_OBB: hit_next = hit_a;
      vot_pkg::CAP_SPH:                    hit_next = cflags.cap_hit;
      vot_pkg::CAP_AABB, vot_pkg::CAP_OBB: hit_next = hit_a | hit_b | hit_m;
      default:                             hit_next = 1'b0;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[LAT-1];
    end
    overlaps <= hit_next;
  end

endmodule

`default_nettype wire

// ===== tb/tb_volume_overlap_test_unit.sv =====
`timescale 1ns / 1ps

module tb_volume_overlap_test_unit;

  localparam int CB = 16;
  localparam int FRAC_AX = CB - 2;
  localparam int N_RANDOM = 1550;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0] func = '0;
  logic [3*CB-1:0] first_start = '0, first_end = '0, second_center = '0;
  logic [CB-1:0] first_radius = '0, second_radius = '0;
  logic [3*CB-1:0] half_size = '0, axis_one = '0, axis_two = '0, axis_three = '0;
  logic done, overlaps;

  typedef struct {
    logic [2:0] fn;
    logic [3*CB-1:0] fs, fe, sc, hs, a1, a2, a3;
    logic [CB-1:0] r1, r2;
  } overlap_req_t;

  // typed-in expectation for directed rows: 0, 1, or -1 for predictor
  typedef struct {
    overlap_req_t rq;
    int fixed;
  } dir_row_t;

  bit hit_queue[$];
  int errors = 0;
  int idle_cycles = 0;
  bit stim_done = 0;

  always #10 clk = ~clk;

  volume_overlap_test_unit #(.COORD_BITS(CB)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .first_start(first_start), .first_end(first_end), .first_radius(first_radius),
    .second_center(second_center), .second_radius(second_radius),
    .half_size(half_size), .axis_one(axis_one), .axis_two(axis_two),
    .axis_three(axis_three), .done(done), .overlaps(overlaps)
  );

  // ---------------- predictor ----------------
  function automatic longint sc_of(logic [3*CB-1:0] w, int i);
    logic signed [CB-1:0] v;
    v = w[i*CB +: CB];
    return longint'(v);
  endfunction

  function automatic longint rnd_shift(longint v);
    longint b;
    b = v + (longint'(1) << (FRAC_AX - 1));
    return b >>> FRAC_AX;
  endfunction

  function automatic longint sq3(longint p[3], longint q[3]);
    longint s;
    s = 0;
    for (int i = 0; i < 3; i++) s += (p[i] - q[i]) * (p[i] - q[i]);
    return s;
  endfunction

  function automatic bit in_aabb(longint p[3], longint r, longint c[3], longint h[3]);
    longint q[3];
    for (int i = 0; i < 3; i++) begin
      q[i] = p[i];
      if (q[i] < c[i] - h[i]) q[i] = c[i] - h[i];
      if (q[i] > c[i] + h[i]) q[i] = c[i] + h[i];
    end
    return sq3(p, q) <= r * r;
  endfunction

  function automatic bit in_obb(longint p[3], longint r, longint c[3], longint h[3],
                                longint ax[9]);
    longint d[3], cl[3], off[3], s;
    for (int i = 0; i < 3; i++) d[i] = p[i] - c[i];
    for (int i = 0; i < 3; i++) begin
      s = 0;
      for (int j = 0; j < 3; j++) s += d[j] * ax[i*3+j];
      cl[i] = rnd_shift(s);
      if (cl[i] < -h[i]) cl[i] = -h[i];
      if (cl[i] > h[i]) cl[i] = h[i];
    end
    for (int j = 0; j < 3; j++) begin
      s = 0;
      for (int i = 0; i < 3; i++) s += ax[i*3+j] * cl[i];
      off[j] = rnd_shift(s);
    end
    return sq3(d, off) <= r * r;
  endfunction

  function automatic bit near_segment(longint a[3], longint b[3], longint p[3], longint r);
    longint dt, len2, ap2;
    logic [127:0] lhs, rhs;
    dt = 0; len2 = 0; ap2 = 0;
    for (int i = 0; i < 3; i++) begin
      dt += (p[i] - a[i]) * (b[i] - a[i]);
      len2 += (b[i] - a[i]) * (b[i] - a[i]);
      ap2 += (p[i] - a[i]) * (p[i] - a[i]);
    end
    if (len2 == 0 || dt <= 0) return ap2 <= r * r;
    if (dt >= len2) return sq3(p, b) <= r * r;
    lhs = 128'(ap2) * 128'(len2);
    rhs = 128'(dt) * 128'(dt) + 128'(r * r) * 128'(len2);
    return lhs <= rhs;
  endfunction

  function automatic bit predict_overlap(overlap_req_t q);
    longint a[3], b[3], c[3], h[3], m[3], ax[9], r1, r2;
    r1 = longint'(q.r1);
    r2 = longint'(q.r2);
    for (int i = 0; i < 3; i++) begin
      a[i] = sc_of(q.fs, i);
      b[i] = sc_of(q.fe, i);
      c[i] = sc_of(q.sc, i);
      h[i] = longint'(q.hs[i*CB +: CB]);
      m[i] = (a[i] + b[i]) >>> 1;
      ax[i] = sc_of(q.a1, i);
      ax[3+i] = sc_of(q.a2, i);
      ax[6+i] = sc_of(q.a3, i);
    end
    case (q.fn)
      vot_pkg::SPH_SPH:  return sq3(a, c) <= (r1 + r2) * (r1 + r2);
      vot_pkg::SPH_AABB: return in_aabb(a, r1, c, h);
      vot_pkg::SPH_OBB:  return in_obb(a, r1, c, h, ax);
      vot_pkg::CAP_SPH:  return near_segment(a, b, c, r1 + r2);
      vot_pkg::CAP_AABB: return in_aabb(a, r1, c, h) || in_aabb(b, r1, c, h) ||
                                in_aabb(m, r1, c, h);
      vot_pkg::CAP_OBB:  return in_obb(a, r1, c, h, ax) || in_obb(b, r1, c, h, ax) ||
                                in_obb(m, r1, c, h, ax);
      default:           return 1'b0;
    endcase
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic logic [3*CB-1:0] pack3(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  function automatic logic [3*CB-1:0] rand_vec(int span);
    int v[3];
    for (int i = 0; i < 3; i++) v[i] = $urandom_range(2 * span) - span;
    return pack3(v[0], v[1], v[2]);
  endfunction

  function automatic logic [3*CB-1:0] rand_full();
    return (3*CB)'({$urandom(), $urandom()});
  endfunction

  // identity or random axes within +-16384, or full random noise
  function automatic overlap_req_t rand_request();
    overlap_req_t q;
    int span;
    q.fn = ($urandom_range(15) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
    if ($urandom_range(9) == 0) begin
      q.fs = rand_full(); q.fe = rand_full(); q.sc = rand_full(); q.hs = rand_full();
      q.a1 = rand_full(); q.a2 = rand_full(); q.a3 = rand_full();
      q.r1 = 16'($urandom()); q.r2 = 16'($urandom());
    end else begin
      span = ($urandom_range(1)) ? 2048 : 16384;
      q.sc = rand_vec(span);
      q.fs = rand_vec(span);
      q.fe = ($urandom_range(7) == 0) ? q.fs : rand_vec(span);
      q.hs = {16'($urandom_range(span)), 16'($urandom_range(span)),
              16'($urandom_range(span))};
      q.r1 = 16'($urandom_range(span));
      q.r2 = 16'($urandom_range(span));
      if ($urandom_range(1)) begin
        q.a1 = pack3(16384, 0, 0); q.a2 = pack3(0, 16384, 0); q.a3 = pack3(0, 0, 16384);
      end else begin
        q.a1 = rand_vec(16384); q.a2 = rand_vec(16384); q.a3 = rand_vec(16384);
      end
    end
    return q;
  endfunction

  // start stays high across back-to-back requests; dropped only for a gap
  task automatic send_request(overlap_req_t q);
    int gap;
    gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    func <= q.fn; first_start <= q.fs; first_end <= q.fe; first_radius <= q.r1;
    second_center <= q.sc; second_radius <= q.r2; half_size <= q.hs;
    axis_one <= q.a1; axis_two <= q.a2; axis_three <= q.a3;
    do @(posedge clk); while (busy);
  endtask

  // ---------------- result checking ----------------
  always @(posedge clk) begin
    if (!rst && done) begin
      if (hit_queue.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual overlaps=%0b",
                 $time, overlaps);
        errors++;
      end else begin
        bit exp_hit;
        exp_hit = hit_queue.pop_front();
        if (overlaps !== exp_hit) begin
          $display("%0t: overlaps mismatch, expected %0b actual %0b",
                   $time, exp_hit, overlaps);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with no request taken and no result
  always @(posedge clk) begin
    if ((start && !busy) || done || stim_done && hit_queue.size() == 0) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // queue expectation when a request is taken
  task automatic issue(overlap_req_t q, int fixed);
    bit h;
    h = predict_overlap(q);
    if (fixed >= 0 && h != fixed[0]) begin
      $display("%0t: directed row disagrees, expected %0d predicted %0b", $time, fixed, h);
      errors++;
    end
    send_request(q);
    hit_queue = {hit_queue, ((fixed >= 0) ? fixed[0] : h)};
  endtask

  initial begin
    dir_row_t rows[$];
    dir_row_t dr;
    overlap_req_t z;
    z.fn = vot_pkg::SPH_SPH; z.fs = '0; z.fe = '0; z.sc = '0; z.hs = '0;
    z.a1 = pack3(16384, 0, 0); z.a2 = pack3(0, 16384, 0); z.a3 = pack3(0, 0, 16384);
    z.r1 = '0; z.r2 = '0;

    // coincident zero-size volumes touch
    dr.rq = z; dr.fixed = 1; rows = {rows, dr};
    // far spheres miss
    dr.rq = z; dr.rq.sc = pack3(256, 0, 0); dr.rq.r1 = 16'd100; dr.rq.r2 = 16'd100;
    dr.fixed = 0; rows = {rows, dr};
    // spheres exactly touching
    dr.rq.r2 = 16'd156; dr.fixed = 1; rows = {rows, dr};
    // extreme corners, max radii
    dr.rq = z; dr.rq.fs = pack3(-32768, -32768, -32768); dr.rq.sc = pack3(32767, 32767, 32767);
    dr.rq.r1 = 16'hFFFF; dr.rq.r2 = 16'hFFFF; dr.fixed = -1; rows = {rows, dr};
    dr.rq.r1 = '0; dr.rq.r2 = '0; dr.fixed = 0; rows = {rows, dr};
    // aabb: centre inside box
    dr.rq = z; dr.rq.fn = vot_pkg::SPH_AABB; dr.rq.hs = pack3(256, 256, 256);
    dr.rq.fs = pack3(100, -100, 50); dr.fixed = 1; rows = {rows, dr};
    dr.rq.fs = pack3(600, 0, 0); dr.rq.r1 = 16'd300; dr.fixed = 0; rows = {rows, dr};
    dr.rq.r1 = 16'd344; dr.fixed = 1; rows = {rows, dr};
    dr.rq.hs = '1; dr.rq.fs = pack3(-32768, 32767, 0); dr.fixed = 1; rows = {rows, dr};
    // obb identity and extremes
    dr.rq = z; dr.rq.fn = vot_pkg::SPH_OBB; dr.rq.hs = pack3(256, 256, 256);
    dr.rq.fs = pack3(0, 0, 100); dr.fixed = 1; rows = {rows, dr};
    dr.rq.fs = pack3(0, 0, 1000); dr.rq.r1 = 16'd10; dr.fixed = 0; rows = {rows, dr};
    dr.rq.a1 = '1; dr.rq.a2 = pack3(-32768, -32768, -32768); dr.rq.a3 = pack3(32767, 32767, 32767);
    dr.rq.hs = '1; dr.rq.r1 = 16'hFFFF; dr.fixed = -1; rows = {rows, dr};
    // capsule-sphere: degenerate segment, interior, beyond end
    dr.rq = z; dr.rq.fn = vot_pkg::CAP_SPH; dr.rq.fs = pack3(10, 10, 10); dr.rq.fe = dr.rq.fs;
    dr.rq.sc = pack3(10, 10, 30); dr.rq.r1 = 16'd10; dr.rq.r2 = 16'd10; dr.fixed = 1;
    rows = {rows, dr};
    dr.rq.sc = pack3(10, 10, 31); dr.fixed = 0; rows = {rows, dr};
    dr.rq.fs = pack3(-1000, 0, 0); dr.rq.fe = pack3(1000, 0, 0); dr.rq.sc = pack3(0, 20, 0);
    dr.fixed = 1; rows = {rows, dr};
    dr.rq.sc = pack3(1030, 0, 0); dr.fixed = 0; rows = {rows, dr};
    dr.rq.fs = pack3(-32768, -32768, -32768); dr.rq.fe = pack3(32767, 32767, 32767);
    dr.rq.sc = pack3(32767, -32768, 0); dr.rq.r1 = 16'hFFFF; dr.fixed = -1; rows = {rows, dr};
    // capsule-box: midpoint only hits
    dr.rq = z; dr.rq.fn = vot_pkg::CAP_AABB; dr.rq.hs = pack3(10, 10, 10);
    dr.rq.fs = pack3(-1000, 0, 0); dr.rq.fe = pack3(1001, 0, 0); dr.fixed = 1;
    rows = {rows, dr};
    dr.rq.fs = pack3(-1000, 500, 0); dr.rq.fe = pack3(1000, 500, 0); dr.fixed = 0;
    rows = {rows, dr};
    dr.rq.fn = vot_pkg::CAP_OBB; dr.rq.fs = pack3(-1000, 0, 0); dr.rq.fe = pack3(1000, 0, 0);
    dr.fixed = 1; rows = {rows, dr};
    dr.rq.fs = pack3(-1000, 500, 0); dr.rq.fe = pack3(1000, 500, 0); dr.fixed = 0;
    rows = {rows, dr};
    // unused func codes never hit
    dr.rq = z; dr.rq.fn = 3'd6; dr.fixed = 0; rows = {rows, dr};
    dr.rq.fn = 3'd7; dr.rq.hs = '1; dr.rq.r1 = '1; dr.fixed = 0; rows = {rows, dr};

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) issue(rows[i].rq, rows[i].fixed);
    for (int n = 0; n < N_RANDOM; n++) issue(rand_request(), -1);
    start <= 1'b0;
    stim_done = 1;

    while (hit_queue.size() != 0) @(posedge clk);
    repeat (4 * (vot_pkg::LANE_LAT + 1)) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/vot_pkg.sv
rtl/vot_wide_mul.sv
rtl/vot_box_lane.sv
rtl/vot_cap_lane.sv
rtl/volume_overlap_test_unit.sv
tb/tb_volume_overlap_test_unit.sv
